// ===== hw/rtl/glr_pkg.sv =====
// gradient line rasterizer package: payload structs, register indexes, constants
// no dependencies
package glr_pkg;

  localparam int CoordBits    = 16;
  localparam int FractionBits = 16;

  localparam logic [1:0] RegFrameWidth  = 2'd0;
  localparam logic [1:0] RegFrameHeight = 2'd1;
  localparam logic [1:0] RegBytesPerPix = 2'd2;
  localparam logic [1:0] RegRowPitch    = 2'd3;

  localparam logic ReqStart   = 1'b0;
  localparam logic ReqAdvance = 1'b1;

  typedef struct packed {
    logic                        req_type;
    logic signed [CoordBits-1:0] x_start;
    logic signed [CoordBits-1:0] y_start;
    logic signed [CoordBits-1:0] x_end;
    logic signed [CoordBits-1:0] y_end;
    logic [7:0]                  start_red;
    logic [7:0]                  start_green;
    logic [7:0]                  start_blue;
    logic [7:0]                  end_red;
    logic [7:0]                  end_green;
    logic [7:0]                  end_blue;
  } glr_in_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] pixel_x;
    logic signed [CoordBits-1:0] pixel_y;
    logic                        in_frame;
    logic [27:0]                 pixel_offset;
    logic [23:0]                 pixel_color;
    logic                        line_done;
  } glr_out_t;

  typedef struct packed {
    logic load;      // start: load line, no step
    logic step;      // advance: bresenham step
    logic dist_calc; // compute distance terms
    logic div_init;  // start divider
    logic div_iter;  // one divider bit
    logic sqrt_init;
    logic sqrt_iter;
    logic blend_mul; // multiply stage
    logic finish;    // capture result
  } glr_cmd_t;

  typedef struct packed {
    logic active;
    logic div_last;
    logic sqrt_last;
  } glr_sts_t;

endpackage

// ===== hw/rtl/glr_datapath.sv =====
// gradient line rasterizer datapath: bresenham state, radial divider, square root, blend
// depends on glr_pkg
module glr_datapath import glr_pkg::*; #(
  parameter int FRACTION_BITS = FractionBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  glr_in_t     req_i,
  input  glr_cmd_t    cmd_i,
  input  logic [12:0] frame_width_i,
  input  logic [12:0] frame_height_i,
  input  logic [3:0]  bytes_per_pixel_i,
  input  logic [15:0] row_pitch_i,
  output glr_sts_t    sts_o,
  output glr_out_t    res_o
);

  localparam int COORD_BITS = CoordBits;
  localparam int SW = COORD_BITS + 1;
  localparam int LW = 2 * SW + 1;
  localparam int QW = 2 * FRACTION_BITS + 1;
  localparam int RW = LW + 1;
  localparam int FW = FRACTION_BITS + 1;
  localparam int DivSteps = QW;
  localparam int SqrtSteps = (QW + 1) / 2;
  localparam int CW = $clog2(DivSteps + 1);

  logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q, org_x_q, org_y_q, tgt_x_q, tgt_y_q;
  logic                         neg_x_q, neg_y_q, active_q;
  logic signed [SW+1:0]         err_q;
  logic [SW-1:0]                span_x_q, span_y_q;
  logic [23:0]                  org_c_q, tgt_c_q;
  logic [LW-1:0]                len_q, d2_q;
  logic [RW-1:0]                rem_q;
  logic [QW-1:0]                quo_q;
  logic [CW-1:0]                cnt_q;
  logic [QW+1:0]                sv_q;
  logic [FW-1:0]                root_q;
  logic [QW+1:0]                srem_q;
  glr_out_t                     res_q;
  logic [FW+8:0]                prod_q [3];

  logic signed [SW:0]           dxs, dys;
  logic [SW-1:0]                adx, ady, sx_n, sy_n;
  logic signed [SW+2:0]         e2;
  logic                         step_x, step_y;
  logic [RW-1:0]                rem_sh;
  logic [QW+1:0]                trial;
  logic                         in_frm, done;
  logic [23:0]                  color;
  logic [27:0]                  offs;

  always_comb begin
    dxs  = (SW+1)'(cur_x_q) - (SW+1)'(org_x_q);
    dys  = (SW+1)'(cur_y_q) - (SW+1)'(org_y_q);
    adx  = dxs[SW] ? SW'(-dxs) : SW'(dxs);
    ady  = dys[SW] ? SW'(-dys) : SW'(dys);
    sx_n = (req_i.x_start > req_i.x_end) ? SW'((SW+1)'(req_i.x_start) - (SW+1)'(req_i.x_end))
                                         : SW'((SW+1)'(req_i.x_end) - (SW+1)'(req_i.x_start));
    sy_n = (req_i.y_start > req_i.y_end) ? SW'((SW+1)'(req_i.y_start) - (SW+1)'(req_i.y_end))
                                         : SW'((SW+1)'(req_i.y_end) - (SW+1)'(req_i.y_start));
    e2     = {err_q, 1'b0};
    step_x = e2 > -$signed((SW+3)'(span_y_q));
    step_y = e2 < $signed((SW+3)'(span_x_q));
    rem_sh = {rem_q[RW-2:0], 1'b0};
    trial  = {srem_q[QW-1:0], sv_q[QW+1:QW]} - {{(QW-FW){1'b0}}, root_q, 2'b01};
    in_frm = !cur_x_q[COORD_BITS-1] && !cur_y_q[COORD_BITS-1] &&
             ($unsigned(cur_x_q) < (COORD_BITS+13)'(frame_width_i)) &&
             ($unsigned(cur_y_q) < (COORD_BITS+13)'(frame_height_i));
    done   = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);
    offs   = 28'(40'($unsigned(cur_x_q)) * 40'(bytes_per_pixel_i) +
                 40'($unsigned(cur_y_q)) * 40'(row_pitch_i));
    for (int i = 0; i < 3; i++) begin
      color[8*i +: 8] = (tgt_c_q[8*i +: 8] >= org_c_q[8*i +: 8]) ?
        8'(org_c_q[8*i +: 8] + prod_q[i][FRACTION_BITS +: 9]) :
        8'(org_c_q[8*i +: 8] - prod_q[i][FRACTION_BITS +: 9]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= '0; cur_y_q <= '0; org_x_q <= '0; org_y_q <= '0;
      tgt_x_q <= '0; tgt_y_q <= '0; neg_x_q <= 1'b0; neg_y_q <= 1'b0;
      err_q <= '0; span_x_q <= '0; span_y_q <= '0; org_c_q <= '0; tgt_c_q <= '0;
      len_q <= '0; active_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        cur_x_q  <= req_i.x_start; cur_y_q <= req_i.y_start;
        org_x_q  <= req_i.x_start; org_y_q <= req_i.y_start;
        tgt_x_q  <= req_i.x_end;   tgt_y_q <= req_i.y_end;
        neg_x_q  <= req_i.x_start > req_i.x_end;
        neg_y_q  <= req_i.y_start > req_i.y_end;
        span_x_q <= sx_n; span_y_q <= sy_n;
        err_q    <= (SW+2)'(sx_n) - (SW+2)'(sy_n);
        len_q    <= LW'(sx_n) * LW'(sx_n) + LW'(sy_n) * LW'(sy_n);
        org_c_q  <= {req_i.start_red, req_i.start_green, req_i.start_blue};
        tgt_c_q  <= {req_i.end_red, req_i.end_green, req_i.end_blue};
      end else if (cmd_i.step) begin
        if (step_x && step_y) begin
          err_q   <= err_q - (SW+2)'(span_y_q) + (SW+2)'(span_x_q);
        end else if (step_x) begin
          err_q   <= err_q - (SW+2)'(span_y_q);
        end else if (step_y) begin
          err_q   <= err_q + (SW+2)'(span_x_q);
        end
        if (step_x) cur_x_q <= neg_x_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
        if (step_y) cur_y_q <= neg_y_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
      end
      if (cmd_i.finish) active_q <= !done;
    end
  end

  // distance, restoring divider for d2*2^(2F+1)/L2 (d2 <= L2), then bitwise root of half
  always_ff @(posedge clk_i) begin
    if (cmd_i.dist_calc) d2_q <= LW'(adx) * LW'(adx) + LW'(ady) * LW'(ady);
    if (cmd_i.div_init) begin
      rem_q <= RW'(d2_q);
      quo_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.div_iter) begin
      if (rem_sh >= RW'(len_q)) begin
        rem_q <= rem_sh - RW'(len_q);
        quo_q <= {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[QW-2:0], 1'b0};
      end
      cnt_q <= cnt_q + 1'b1;
    end else if (cmd_i.sqrt_init) begin
      // d2 == L2 gives one; zero length gives zero
      sv_q   <= (len_q == '0) ? '0 :
                (d2_q == len_q) ? (QW+2)'(1) << (2*FRACTION_BITS+1) :
                (QW+2)'({rem_q >= RW'(len_q), quo_q});
      root_q <= '0;
      srem_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.sqrt_iter) begin
      sv_q <= {sv_q[QW-1:0], 2'b00};
      if (!trial[QW+1]) begin
        srem_q <= trial;
        root_q <= {root_q[FW-2:0], 1'b1};
      end else begin
        srem_q <= {srem_q[QW-1:0], sv_q[QW+1:QW]};
        root_q <= {root_q[FW-2:0], 1'b0};
      end
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.blend_mul) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= (FW+9)'((tgt_c_q[8*i +: 8] >= org_c_q[8*i +: 8]) ?
                     tgt_c_q[8*i +: 8] - org_c_q[8*i +: 8] :
                     org_c_q[8*i +: 8] - tgt_c_q[8*i +: 8]) * (FW+9)'(root_q);
      end
    end
    if (cmd_i.finish) begin
      res_q.pixel_x      <= cur_x_q;
      res_q.pixel_y      <= cur_y_q;
      res_q.in_frame     <= in_frm;
      res_q.pixel_offset <= in_frm ? offs : '0;
      res_q.pixel_color  <= color;
      res_q.line_done    <= done;
    end
  end

  assign sts_o.active    = active_q;
  assign sts_o.div_last  = (cnt_q == CW'(DivSteps - 1));
  assign sts_o.sqrt_last = (cnt_q == CW'(SqrtSteps - 1));
  assign res_o           = res_q;

endmodule

// ===== hw/rtl/glr_controller.sv =====
// gradient line rasterizer controller: sequences one transaction through the datapath
// depends on glr_pkg
module glr_controller import glr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     req_type_i,
  output logic     out_valid,
  input  logic     out_stall,
  input  glr_sts_t sts_i,
  output glr_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle, StDist, StDivInit, StDiv, StSqrtInit, StSqrt, StMul, StFin
  } state_e;

  state_e state_q;
  logic   ovalid_q;
  logic   acc;

  assign in_stall  = (state_q != StIdle) || (ovalid_q && out_stall);
  assign acc       = in_valid && !in_stall;
  assign out_valid = ovalid_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = acc && (req_type_i == ReqStart);
    cmd_o.step      = acc && (req_type_i == ReqAdvance) && sts_i.active;
    cmd_o.dist_calc = (state_q == StDist);
    cmd_o.div_init  = (state_q == StDivInit);
    cmd_o.div_iter  = (state_q == StDiv);
    cmd_o.sqrt_init = (state_q == StSqrtInit);
    cmd_o.sqrt_iter = (state_q == StSqrt);
    cmd_o.blend_mul = (state_q == StMul);
    cmd_o.finish    = (state_q == StFin);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
    end else begin
      if (state_q == StFin) ovalid_q <= 1'b1;
      else if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
      case (state_q)
        StIdle:     if (cmd_o.load || cmd_o.step) state_q <= StDist;
        StDist:     state_q <= StDivInit;
        StDivInit:  state_q <= StDiv;
        StDiv:      if (sts_i.div_last) state_q <= StSqrtInit;
        StSqrtInit: state_q <= StSqrt;
        StSqrt:     if (sts_i.sqrt_last) state_q <= StMul;
        StMul:      state_q <= StFin;
        StFin:      state_q <= StIdle;
        default:    state_q <= StIdle;
      endcase
    end
  end

endmodule

// ===== hw/rtl/gradient_line_rasterizer_unit.sv =====
// gradient line rasterizer top level: config registers, controller and datapath
// depends on glr_pkg, glr_controller, glr_datapath
//
// channel  direction  handshake               payload
// in       input      in_valid / in_stall     glr_in_t
// out      output     out_valid / out_stall   glr_out_t
// cfg      input      cfg_valid / cfg_ready   cfg_index_i, cfg_data_i
//
// a pixel passes the distance, divider, square root and blend steps in order,
// the divider and square root being bit-serial; the next transaction is taken
// only once the controller has returned to idle after the pixel is registered
// an advance with no line in progress is taken in idle and gives no pixel
// input stalls while a pixel is in work or the previous result is still stalled
// reset restores default frame registers and drops any line
module gradient_line_rasterizer_unit import glr_pkg::*; #(
  parameter int FRACTION_BITS = FractionBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  glr_in_t     in_data_i,
  output logic        out_valid,
  input  logic        out_stall,
  output glr_out_t    out_data_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [12:0] fw_q, fh_q;
  logic [3:0]  bpp_q;
  logic [15:0] pitch_q;
  glr_cmd_t    cmd;
  glr_sts_t    sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= 13'd640; fh_q <= 13'd480; bpp_q <= 4'd4; pitch_q <= 16'd2560;
    end else if (cfg_valid) begin
      case (cfg_index_i)
        RegFrameWidth:  fw_q    <= cfg_data_i[12:0];
        RegFrameHeight: fh_q    <= cfg_data_i[12:0];
        RegBytesPerPix: bpp_q   <= cfg_data_i[3:0];
        RegRowPitch:    pitch_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  glr_controller u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall,
    .req_type_i (in_data_i.req_type),
    .out_valid, .out_stall,
    .sts_i (sts), .cmd_o (cmd)
  );

  glr_datapath #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
    .clk_i, .rst_ni,
    .req_i (in_data_i), .cmd_i (cmd),
    .frame_width_i (fw_q), .frame_height_i (fh_q),
    .bytes_per_pixel_i (bpp_q), .row_pitch_i (pitch_q),
    .sts_o (sts), .res_o (out_data_o)
  );

endmodule

// ===== verif/tb_gradient_line_rasterizer_unit.sv =====
// testbench for gradient_line_rasterizer_unit: directed table, then random lines under
// random idling on both channels, checked against an in-bench pixel predictor
// depends on glr_pkg and the rtl of gradient_line_rasterizer_unit
`timescale 1ns / 100ps

module tb_gradient_line_rasterizer_unit;
  import glr_pkg::*;

  localparam int LimitCycles = 900000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  glr_in_t     in_data_i = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  glr_out_t    out_data_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index_i = RegFrameWidth;
  logic [15:0] cfg_data_i = '0;

  gradient_line_rasterizer_unit i_dut (
    .clk_i, .rst_ni, .in_valid, .in_stall, .in_data_i,
    .out_valid, .out_stall, .out_data_o,
    .cfg_valid, .cfg_ready, .cfg_index_i, .cfg_data_i
  );

  always #4 clk_i = ~clk_i;

  // predictor state
  longint          cur_x, cur_y, org_x, org_y, tgt_x, tgt_y, err_t, span_x, span_y;
  bit              neg_x, neg_y, line_on;
  logic [23:0]     org_col, tgt_col;
  longint unsigned len2;
  longint unsigned frame_w = 640, frame_h = 480, pix_bytes = 4, pitch = 2560;

  glr_out_t pixel_q[$];
  int       errors = 0, pixels_seen = 0, items_sent = 0, cycles = 0;
  bit       calm = 1'b0;

  function automatic longint unsigned sq(longint d);
    longint unsigned m;
    m = (d < 0) ? longint'(-d) : d;
    return m * m;
  endfunction

  function automatic glr_out_t shade_pixel();
    longint unsigned d2, q, v, res, bitv, a, b, mag;
    logic [127:0]    w;
    logic [23:0]     col;
    glr_out_t        o;
    bit              in_frm;
    d2 = sq(cur_x - org_x) + sq(cur_y - org_y);
    if (len2 == 0) begin
      q = 0;
    end else begin
      w = ({64'd0, d2} << 32) / len2;
      q = (w > 128'h1_0000_0000) ? 64'h1_0000_0000 : w[63:0];
    end
    v = q;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    for (int sh = 0; sh < 24; sh += 8) begin
      a = (org_col >> sh) & 8'hFF;
      b = (tgt_col >> sh) & 8'hFF;
      if (b >= a) begin
        mag = ((b - a) * res) >> FractionBits;
        col[sh+:8] = 8'(a + mag);
      end else begin
        mag = ((a - b) * res) >> FractionBits;
        col[sh+:8] = 8'(a - mag);
      end
    end
    in_frm = cur_x >= 0 && cur_y >= 0 && cur_x < longint'(frame_w) &&
             cur_y < longint'(frame_h);
    o.pixel_x      = cur_x[15:0];
    o.pixel_y      = cur_y[15:0];
    o.in_frame     = in_frm;
    o.pixel_offset = in_frm ? 28'(longint'(cur_x) * pix_bytes + longint'(cur_y) * pitch) : '0;
    o.pixel_color  = col;
    o.line_done    = (cur_x == tgt_x) && (cur_y == tgt_y);
    line_on        = !o.line_done;
    return o;
  endfunction

  function automatic bit rasterize(glr_in_t t, output glr_out_t o);
    longint e2;
    if (t.req_type == ReqStart) begin
      org_x = longint'($signed(t.x_start));
      org_y = longint'($signed(t.y_start));
      tgt_x = longint'($signed(t.x_end));
      tgt_y = longint'($signed(t.y_end));
      org_col = {t.start_red, t.start_green, t.start_blue};
      tgt_col = {t.end_red, t.end_green, t.end_blue};
      neg_x = org_x > tgt_x;
      neg_y = org_y > tgt_y;
      span_x = neg_x ? org_x - tgt_x : tgt_x - org_x;
      span_y = neg_y ? org_y - tgt_y : tgt_y - org_y;
      err_t = span_x - span_y;
      len2 = sq(span_x) + sq(span_y);
      cur_x = org_x;
      cur_y = org_y;
      o = shade_pixel();
      return 1'b1;
    end
    o = '0;
    if (!line_on) return 1'b0;
    e2 = 2 * err_t;
    if (e2 > -span_y) begin
      err_t -= span_y;
      cur_x += neg_x ? -1 : 1;
    end
    if (e2 < span_x) begin
      err_t += span_x;
      cur_y += neg_y ? -1 : 1;
    end
    o = shade_pixel();
    return 1'b1;
  endfunction

  function automatic glr_in_t mk_start(int xs, int ys, int xe, int ye,
                                       logic [23:0] sc, logic [23:0] ec);
    glr_in_t t;
    t.req_type = ReqStart;
    t.x_start = 16'(xs);
    t.y_start = 16'(ys);
    t.x_end = 16'(xe);
    t.y_end = 16'(ye);
    {t.start_red, t.start_green, t.start_blue} = sc;
    {t.end_red, t.end_green, t.end_blue} = ec;
    return t;
  endfunction

  function automatic glr_in_t mk_advance();
    glr_in_t      t;
    logic [127:0] r;
    r = {$urandom, $urandom, $urandom, $urandom};
    t = r[$bits(glr_in_t)-1:0];
    t.req_type = ReqAdvance;
    return t;
  endfunction

  // sends one transaction; typed rows override the predicted pixel
  task automatic send_item(glr_in_t t, bit typed, bit typed_has, glr_out_t typed_pix,
                           output bit got);
    int       gap;
    glr_out_t o;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data_i <= t;
    do @(posedge clk_i); while (in_stall);
    got = rasterize(t, o);
    if (typed) begin
      if (typed_has != got) begin
        $display("%0t: result presence expected %0b predicted %0b", $time, typed_has, got);
        errors++;
      end
      got = typed_has;
      o = typed_pix;
    end
    if (got) pixel_q.push_back(o);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [15:0] w, logic [15:0] h, logic [15:0] bpp,
                            logic [15:0] rp);
    logic [15:0] vals [4];
    logic [1:0]  idx [4];
    vals = '{w, h, bpp, rp};
    idx = '{RegFrameWidth, RegFrameHeight, RegBytesPerPix, RegRowPitch};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i <= vals[i];
      do @(posedge clk_i); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    frame_w = w & 16'h1FFF;
    frame_h = h & 16'h1FFF;
    pix_bytes = bpp & 16'hF;
    pitch = rp;
  endtask

  task automatic report(string name, longint unsigned e, longint unsigned a);
    $display("%0t: %s expected %0h actual %0h", $time, name, e, a);
    errors++;
  endtask

  always @(posedge clk_i) begin
    glr_out_t e;
    if (out_valid && !out_stall) begin
      pixels_seen++;
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected pixel expected none actual %0h", $time, out_data_o);
        errors++;
      end else begin
        e = pixel_q.pop_front();
        if (out_data_o.pixel_x !== e.pixel_x) report("pixel_x", e.pixel_x, out_data_o.pixel_x);
        if (out_data_o.pixel_y !== e.pixel_y) report("pixel_y", e.pixel_y, out_data_o.pixel_y);
        if (out_data_o.in_frame !== e.in_frame)
          report("in_frame", e.in_frame, out_data_o.in_frame);
        if (out_data_o.pixel_offset !== e.pixel_offset)
          report("pixel_offset", e.pixel_offset, out_data_o.pixel_offset);
        if (out_data_o.pixel_color !== e.pixel_color)
          report("pixel_color", e.pixel_color, out_data_o.pixel_color);
        if (out_data_o.line_done !== e.line_done)
          report("line_done", e.line_done, out_data_o.line_done);
      end
    end
  end

  // receiver stall, redrawn per pixel
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = calm ? 0 : $urandom_range(0, 11);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == LimitCycles) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  typedef struct {
    glr_in_t  item;
    bit       typed;
    bit       has_pix;
    glr_out_t pix;
  } row_t;

  row_t table_q[$];

  function automatic glr_out_t pix(int x, int y, bit inf, int off, logic [23:0] c, bit dn);
    glr_out_t o;
    o.pixel_x = 16'(x);
    o.pixel_y = 16'(y);
    o.in_frame = inf;
    o.pixel_offset = 28'(off);
    o.pixel_color = c;
    o.line_done = dn;
    return o;
  endfunction

  task automatic run_lines(int pixel_target);
    int       got_pix, mode, xs, ys, n_adv, span;
    bit       got;
    glr_in_t  t;
    got_pix = 0;
    while (got_pix < pixel_target) begin
      if (($urandom_range(0, 39)) == 0) calm = ~calm;
      mode = $urandom_range(0, 19);
      span = ($urandom_range(0, 9) == 0) ? 60 : 12;
      xs = $urandom_range(0, 60) - 10;
      ys = $urandom_range(0, 60) - 10;
      if (mode == 0) begin
        t = mk_advance();
      end else if (mode <= 2) begin
        t = mk_start($urandom, $urandom, $urandom, $urandom, 24'($urandom), 24'($urandom));
      end else begin
        t = mk_start(xs, ys, xs + $urandom_range(0, 2 * span) - span,
                     ys + $urandom_range(0, 2 * span) - span, 24'($urandom), 24'($urandom));
      end
      send_item(t, 1'b0, 1'b0, '0, got);
      got_pix += got;
      n_adv = (mode <= 2 || $urandom_range(0, 6) == 0) ? $urandom_range(0, 6) : 200;
      for (int i = 0; i < n_adv && (line_on || $urandom_range(0, 3) == 0); i++) begin
        send_item(mk_advance(), 1'b0, 1'b0, '0, got);
        got_pix += got;
      end
    end
    drain();
  endtask

  initial begin
    bit got;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at reset defaults
    table_q.push_back('{mk_advance(), 1'b1, 1'b0, '0});
    table_q.push_back('{mk_start(3, 2, 3, 2, 24'hAA5501, 24'h00FF77), 1'b1, 1'b1,
                        pix(3, 2, 1'b1, 5132, 24'hAA5501, 1'b1)});
    table_q.push_back('{mk_advance(), 1'b1, 1'b0, '0});
    table_q.push_back('{mk_start(-1, 0, -1, 0, 24'h123456, 24'hFFFFFF), 1'b1, 1'b1,
                        pix(-1, 0, 1'b0, 0, 24'h123456, 1'b1)});
    table_q.push_back('{mk_start(639, 479, 639, 479, 24'hFFFFFF, 24'h0), 1'b1, 1'b1,
                        pix(639, 479, 1'b1, 1228796, 24'hFFFFFF, 1'b1)});
    table_q.push_back('{mk_start(640, 0, 640, 0, 24'h0, 24'hFFFFFF), 1'b1, 1'b1,
                        pix(640, 0, 1'b0, 0, 24'h0, 1'b1)});
    table_q.push_back('{mk_start(0, 0, 4, 0, 24'h0, 24'hFFFFFF), 1'b1, 1'b1,
                        pix(0, 0, 1'b1, 0, 24'h0, 1'b0)});
    for (int i = 0; i < 5; i++) table_q.push_back('{mk_advance(), 1'b0, 1'b0, '0});
    table_q.push_back('{mk_start(-32768, -32768, 32767, 32767, 24'hFF00FF, 24'h00FF00),
                        1'b0, 1'b0, '0});
    table_q.push_back('{mk_advance(), 1'b0, 1'b0, '0});
    table_q.push_back('{mk_start(32767, 32767, -32768, -32768, 24'h00FF00, 24'hFF00FF),
                        1'b0, 1'b0, '0});
    table_q.push_back('{mk_advance(), 1'b0, 1'b0, '0});
    table_q.push_back('{mk_start(5, 5, 2, -3, 24'hFFFFFF, 24'h000000), 1'b0, 1'b0, '0});
    for (int i = 0; i < 9; i++) table_q.push_back('{mk_advance(), 1'b0, 1'b0, '0});
    foreach (table_q[i])
      send_item(table_q[i].item, table_q[i].typed, table_q[i].has_pix, table_q[i].pix, got);
    drain();

    run_lines(150);
    write_regs(16'd4096, 16'd4096, 16'd8, 16'd65535);
    run_lines(150);
    write_regs(16'd1, 16'd1, 16'd1, 16'd1);
    run_lines(120);
    write_regs(16'hFFFF, 16'd0, 16'hF, 16'hFFFF);
    run_lines(100);
    write_regs(16'($urandom_range(1, 4096)), 16'($urandom_range(1, 4096)),
               16'($urandom_range(1, 8)), 16'($urandom_range(1, 65535)));
    run_lines(150);

    $display("covered %0d input transactions and %0d pixels over five register settings",
             items_sent, pixels_seen);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
